@@ hw/rtl/sgmd_pkg.sv @@
// Shared types and constants for the Sobel gradient magnitude/direction block.
// No dependencies; every other RTL file imports this package.
package sgmd_pkg;

    // frame geometry
    localparam int MAX_WIDTH    = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = 12;
    localparam int WIDTH_W      = 11;
    localparam int HEIGHT_W     = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int PIX_W        = 8;
    localparam int GRAD_W       = 11;
    localparam int ABS_W        = 10;

    localparam logic [WIDTH_W-1:0]  MIN_WIDTH    = 11'd3;
    localparam logic [WIDTH_W-1:0]  LIMIT_WIDTH  = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] MIN_HEIGHT   = 13'd3;
    localparam logic [HEIGHT_W-1:0] LIMIT_HEIGHT = 13'd4096;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    // configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // sector thresholds, tan 22.5 and tan 67.5 in 2^-24 units
    localparam int PROD_W = 36;
    localparam logic [PROD_W-1:0] TAN_LOW_Q24  = 36'd6949350;
    localparam logic [PROD_W-1:0] TAN_HIGH_Q24 = 36'd40503782;

    // direction codes
    localparam logic [1:0] DIR_HORIZONTAL = 2'd0;
    localparam logic [1:0] DIR_PLUS_45    = 2'd1;
    localparam logic [1:0] DIR_VERTICAL   = 2'd2;
    localparam logic [1:0] DIR_MINUS_45   = 2'd3;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QLW    = QAW + 1;

    // one classified window: gradients plus position flags
    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     eor;
        logic                     eof;
    } sgmd_item_t;

endpackage

@@ hw/rtl/sgmd_front.sv @@
// Front end: pixel intake, line store, 3x3 window and Sobel gradients.
// Depends on sgmd_pkg; feeds sgmd_queue.
module sgmd_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [sgmd_pkg::WIDTH_W-1:0]     image_width,
    input  logic [sgmd_pkg::HEIGHT_W-1:0]    image_height,
    input  logic                             pixel_valid,
    output logic                             pixel_ready,
    input  logic [sgmd_pkg::PIX_W-1:0]       pixel,
    input  logic [sgmd_pkg::QLW-1:0]         q_level,
    output logic                             q_push,
    output sgmd_pkg::sgmd_item_t             q_item
);
    import sgmd_pkg::*;

    logic [COL_W-1:0]       col_reg, col_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [WIDTH_W-1:0]     w_eff;
    logic [HEIGHT_W-1:0]    h_eff;
    logic                   last_col, last_row, accept;

    logic                   b_valid_reg;
    logic [PIX_W-1:0]       b_pix_reg;
    logic [COL_W-1:0]       b_col_reg;
    logic                   b_produce_reg, b_eor_reg, b_eof_reg;

    logic [2*PIX_W-1:0]     line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0]     rd_data_reg;
    logic [PIX_W-1:0]       win_reg [6];

    logic [PIX_W-1:0]       top, mid, bot;
    logic [ABS_W-1:0]       sum_r, sum_l, sum_t, sum_b;

    // accept only while the queue can absorb the window in flight
    assign pixel_ready = (q_level + QLW'(b_valid_reg)) < QLW'(QDEPTH);
    assign accept      = pixel_valid & pixel_ready;

    // clamp the frame size
    always_comb
    begin
        w_eff = image_width;
        if (image_width < MIN_WIDTH)
            w_eff = MIN_WIDTH;
        else if (image_width > LIMIT_WIDTH)
            w_eff = LIMIT_WIDTH;
        h_eff = image_height;
        if (image_height < MIN_HEIGHT)
            h_eff = MIN_HEIGHT;
        else if (image_height > LIMIT_HEIGHT)
            h_eff = LIMIT_HEIGHT;
    end

    assign last_col = ({1'b0, col_reg} + WIDTH_W'(1)) >= w_eff;
    assign last_row = ({1'b0, row_reg} + HEIGHT_W'(1)) >= h_eff;

    // advance the raster position
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // position counters and the window stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            b_valid_reg   <= 1'b0;
            b_produce_reg <= 1'b0;
            b_eor_reg     <= 1'b0;
            b_eof_reg     <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            b_valid_reg <= accept;
            if (accept)
            begin
                b_produce_reg <= (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
                b_eor_reg     <= last_col;
                b_eof_reg     <= last_col & last_row;
            end
        end
    end

    // hold the pixel and its column for the window stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_pix_reg <= pixel;
            b_col_reg <= col_reg;
        end
    end

    // line store: upper byte is the older row, lower byte the newer row
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= line_mem[col_reg];
        if (b_valid_reg)
            line_mem[b_col_reg] <= {rd_data_reg[PIX_W-1:0], b_pix_reg};
    end

    assign top = rd_data_reg[2*PIX_W-1:PIX_W];
    assign mid = rd_data_reg[PIX_W-1:0];
    assign bot = b_pix_reg;

    // shift the window one column left
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (b_valid_reg)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= bot;
        end
    end

    // weighted column and row sums
    assign sum_r = ABS_W'(top) + {1'b0, mid, 1'b0} + ABS_W'(bot);
    assign sum_l = ABS_W'(win_reg[0]) + {1'b0, win_reg[1], 1'b0} + ABS_W'(win_reg[2]);
    assign sum_t = ABS_W'(win_reg[0]) + {1'b0, win_reg[3], 1'b0} + ABS_W'(top);
    assign sum_b = ABS_W'(win_reg[2]) + {1'b0, win_reg[5], 1'b0} + ABS_W'(bot);

    assign q_push     = b_valid_reg & b_produce_reg;
    assign q_item.gx  = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
    assign q_item.gy  = $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
    assign q_item.eor = b_eor_reg;
    assign q_item.eof = b_eof_reg;

endmodule

@@ hw/rtl/sgmd_queue.sv @@
// Short FIFO of gradient requests between the front and back ends.
// Depends on sgmd_pkg.
module sgmd_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  sgmd_pkg::sgmd_item_t        push_item,
    input  logic                        pop,
    output logic                        head_valid,
    output sgmd_pkg::sgmd_item_t        head_item,
    output logic [sgmd_pkg::QLW-1:0]    level
);
    import sgmd_pkg::*;

    sgmd_item_t         slot_reg [QDEPTH];
    logic [QAW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QLW-1:0]     count_reg;
    logic               do_pop;

    assign do_pop     = pop & (count_reg != '0);
    assign head_valid = count_reg != '0;
    assign head_item  = slot_reg[rd_ptr_reg];
    assign level      = count_reg;

    // advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            count_reg <= count_reg + QLW'(push) - QLW'(do_pop);
        end
    end

    // store the incoming request
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

@@ hw/rtl/sgmd_back.sv @@
// Back end: squares, sector compare, bit-serial square root, result register.
// Depends on sgmd_pkg; drains sgmd_queue.
module sgmd_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  sgmd_pkg::sgmd_item_t            q_item,
    output logic                            q_pop,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [sgmd_pkg::PIX_W-1:0]      gradient_magnitude,
    output logic [1:0]                      edge_direction,
    output logic                            end_of_row,
    output logic                            end_of_frame
);
    import sgmd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_ROOT = 3'd3;
    localparam logic [2:0] ST_HOLD = 3'd4;

    localparam int SQ_W  = 2 * ABS_W;
    localparam int SUM_W = SQ_W + 1;
    localparam int REM_W = 16;

    logic [2:0]             state_reg, state_next;
    sgmd_item_t             item_reg;

    logic [GRAD_W-1:0]      gx_abs_full, gy_abs_full;
    logic [ABS_W-1:0]       ax, ay;

    logic [SQ_W-1:0]        sqx_reg, sqy_reg;
    logic [PROD_W-1:0]      lo_reg, hi_reg, lhs_reg;
    logic [SUM_W-1:0]       sum_sq;

    logic [REM_W-1:0]       rem_reg;
    logic [REM_W-1:0]       root_reg;
    logic [REM_W-2:0]       bit_reg;
    logic                   sat_reg;
    logic [REM_W:0]         trial;

    logic                   gx_zero, gy_zero, same_sign;
    logic [1:0]             sector;
    logic                   out_free;

    assign q_pop    = (state_reg == ST_IDLE) & q_valid;
    assign out_free = !result_valid || result_ready;

    // sequence one request at a time
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_valid) state_next = ST_MUL;
            ST_MUL:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_ROOT;
            ST_ROOT: if (bit_reg[0]) state_next = ST_HOLD;
            ST_HOLD: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // take the request off the queue
    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_item;
    end

    assign gx_abs_full = item_reg.gx[GRAD_W-1] ? GRAD_W'(-item_reg.gx) : item_reg.gx;
    assign gy_abs_full = item_reg.gy[GRAD_W-1] ? GRAD_W'(-item_reg.gy) : item_reg.gy;
    assign ax = gx_abs_full[ABS_W-1:0];
    assign ay = gy_abs_full[ABS_W-1:0];

    // squares and threshold products
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            sqx_reg <= ax * ax;
            sqy_reg <= ay * ay;
            lo_reg  <= TAN_LOW_Q24 * PROD_W'(ax);
            hi_reg  <= TAN_HIGH_Q24 * PROD_W'(ax);
            lhs_reg <= PROD_W'({ay, 24'b0});
        end
    end

    assign sum_sq = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
    assign trial  = (REM_W+1)'(root_reg) + (REM_W+1)'(bit_reg);

    // square root, two bits of the radicand per cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            rem_reg  <= sum_sq[REM_W-1:0];
            sat_reg  <= sum_sq[SUM_W-1:REM_W] != '0;
            root_reg <= '0;
            bit_reg  <= {1'b1, {(REM_W-2){1'b0}}};
        end
        else if (state_reg == ST_ROOT)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_reg  <= rem_reg - trial[REM_W-1:0];
                root_reg <= (root_reg >> 1) + REM_W'(bit_reg);
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // classify the angle into a sector
    assign gx_zero   = item_reg.gx == '0;
    assign gy_zero   = item_reg.gy == '0;
    assign same_sign = item_reg.gx[GRAD_W-1] == item_reg.gy[GRAD_W-1];

    always_comb
    begin
        if (gx_zero)
            sector = DIR_VERTICAL;
        else if (gy_zero)
            sector = DIR_HORIZONTAL;
        else if (same_sign)
        begin
            if (lhs_reg <= lo_reg)
                sector = DIR_HORIZONTAL;
            else if (lhs_reg <= hi_reg)
                sector = DIR_PLUS_45;
            else
                sector = DIR_VERTICAL;
        end
        else
        begin
            if (lhs_reg < lo_reg)
                sector = DIR_HORIZONTAL;
            else if (lhs_reg < hi_reg)
                sector = DIR_MINUS_45;
            else
                sector = DIR_VERTICAL;
        end
    end

    // result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else if (state_reg == ST_HOLD && out_free)
            result_valid <= 1'b1;
        else if (result_ready)
            result_valid <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_HOLD && out_free)
        begin
            gradient_magnitude <= sat_reg ? {PIX_W{1'b1}} : root_reg[PIX_W-1:0];
            edge_direction     <= sector;
            end_of_row         <= item_reg.eor;
            end_of_frame       <= item_reg.eof;
        end
    end

endmodule

@@ hw/rtl/sobel_gradient_magnitude_direction_top.sv @@
// Throughput: pixels at one per cycle until the 4-deep queue fills; then the back end takes
// one window at a time, paced by the square-root unit (one root bit a cycle) and result_ready.
// Reset: sizes go to 640x480, position and window clear; the line store is not cleared.
// Depends on sgmd_pkg, sgmd_front, sgmd_queue, sgmd_back.
module sobel_gradient_magnitude_direction_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic                                cfg_index,
    input  logic [sgmd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                pixel_valid,
    output logic                                pixel_ready,
    input  logic [sgmd_pkg::PIX_W-1:0]          pixel,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [sgmd_pkg::PIX_W-1:0]          gradient_magnitude,
    output logic [1:0]                          edge_direction,
    output logic                                end_of_row,
    output logic                                end_of_frame
);
    import sgmd_pkg::*;

    logic [WIDTH_W-1:0]     width_reg;
    logic [HEIGHT_W-1:0]    height_reg;

    logic                   q_push, q_pop, q_valid;
    sgmd_item_t             push_item, head_item;
    logic [QLW-1:0]         q_level;

    // size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    sgmd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (width_reg),
        .image_height (height_reg),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .q_level      (q_level),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    sgmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_item  (head_item),
        .level      (q_level)
    );

    sgmd_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_valid            (q_valid),
        .q_item             (head_item),
        .q_pop              (q_pop),
        .result_valid       (result_valid),
        .result_ready       (result_ready),
        .gradient_magnitude (gradient_magnitude),
        .edge_direction     (edge_direction),
        .end_of_row         (end_of_row),
        .end_of_frame       (end_of_frame)
    );

endmodule

@@ hw/rtl/sgmd_checker.sv @@
// Port-level checks for the Sobel gradient block, bound to the top level.
// Depends on sgmd_pkg.
module sgmd_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                result_valid,
    input  logic                                result_ready,
    input  logic [sgmd_pkg::PIX_W-1:0]          gradient_magnitude,
    input  logic [1:0]                          edge_direction,
    input  logic                                end_of_row,
    input  logic                                end_of_frame
);
    import sgmd_pkg::*;

    // hold a stalled result
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            $stable(gradient_magnitude) && $stable(edge_direction) &&
            $stable(end_of_row) && $stable(end_of_frame))
        else $error("result payload changed while stalled");

    // a frame ends only at the end of a row
    a_frame_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && end_of_frame |-> end_of_row)
        else $error("end_of_frame without end_of_row");

    // a flat window has no horizontal gradient, so it reads as vertical
    a_flat_is_vertical: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && gradient_magnitude == '0 |-> edge_direction == DIR_VERTICAL)
        else $error("zero magnitude with non-vertical direction");

endmodule

bind sobel_gradient_magnitude_direction_top sgmd_checker u_sgmd_checker (.*);
